// ----- hw/rtl/rfk_pkg.sv -----
// Shared types and constants of the rank fusion top-k block.
package rfk_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FUSION_MODE = 3'd0,
        REG_RANK_K      = 3'd1,
        REG_TOP_K       = 3'd2,
        REG_WEIGHT0     = 3'd3,
        REG_WEIGHT1     = 3'd4,
        REG_WEIGHT2     = 3'd5,
        REG_WEIGHT3     = 3'd6,
        REG_DIST_MASK   = 3'd7
    } t_reg_idx;

    localparam logic [15:0] K_DEFAULT    = 16'd960;
    localparam logic [4:0]  TOP_K_RESET  = 5'd10;
    localparam logic [15:0] WEIGHT_RESET = 16'd4096;

    localparam int unsigned DIV_DVD_W = 48;
    localparam int unsigned DIV_DVS_W = 33;
    localparam int unsigned TERM_W    = 25;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic clr_run;
        logic fuse_init;
        logic item_rd;
        logic div_start;
        logic mul_capture;
        logic scan_rd;
        logic scan_step;
        logic uniq_update;
        logic uniq_append;
        logic item_next;
        logic sel_init;
        logic sel_rd;
        logic sel_insert;
        logic emit;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic items_done;
        logic div_done;
        logic scan_end;
        logic id_match;
        logic sel_done;
        logic emit_done;
    } t_stat;

endpackage

// ----- hw/rtl/rfk_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module rfk_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rfk_pkg::DIV_DVD_W-1:0]      i_dividend,
    input  logic [rfk_pkg::DIV_DVS_W-1:0]      i_divisor,
    output logic [rfk_pkg::DIV_DVD_W-1:0]      o_quotient,
    output logic                               o_done
);
    localparam int unsigned DVD_W = rfk_pkg::DIV_DVD_W;
    localparam int unsigned DVS_W = rfk_pkg::DIV_DVS_W;
    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             rem_ge;

    assign rem_sh   = {r_rem, r_quo[DVD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], rem_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- hw/rtl/rfk_datapath.sv -----
// Datapath: configuration, item and unique-id stores, term unit and top-k list.
module rfk_datapath #(
    parameter int unsigned NUM_LISTS     = 4,
    parameter int unsigned ITEM_CAPACITY = 256,
    parameter int unsigned TOP_K_MAX     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rfk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                       i_list_index,
    input  logic [63:0]                      i_in_chunk_id,
    input  logic signed [31:0]               i_raw_score,
    input  logic                             i_entry_valid,
    input  rfk_pkg::t_cmd                    i_cmd,
    output rfk_pkg::t_stat                   o_stat,
    output logic                             o_valid,
    output logic [63:0]                      o_out_chunk_id,
    output logic [31:0]                      o_fused_score,
    output logic                             o_overflow,
    output logic                             o_out_last
);
    localparam int unsigned AW     = $clog2(ITEM_CAPACITY);
    localparam int unsigned CW     = $clog2(ITEM_CAPACITY + 1);
    localparam int unsigned LW     = $clog2(NUM_LISTS);
    localparam int unsigned LIMW   = $clog2(TOP_K_MAX + 1);
    localparam int unsigned KW     = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1;
    localparam int unsigned TERM_W = rfk_pkg::TERM_W;
    localparam int unsigned DVD_W  = rfk_pkg::DIV_DVD_W;
    localparam int unsigned DVS_W  = rfk_pkg::DIV_DVS_W;

    // Configuration registers.
    logic        r_mode;
    logic [15:0] r_k;
    logic [4:0]  r_top_k;
    logic [15:0] r_weight [4];
    logic [3:0]  r_dist;

    // Item store.
    logic [63:0]        r_mem_id    [ITEM_CAPACITY];
    logic signed [31:0] r_mem_score [ITEM_CAPACITY];
    logic [1:0]         r_mem_list  [ITEM_CAPACITY];
    logic [AW-1:0]      r_mem_rank  [ITEM_CAPACITY];
    logic [63:0]        r_rd_id;
    logic signed [31:0] r_rd_score;
    logic [1:0]         r_rd_list;
    logic [AW-1:0]      r_rd_rank;

    // Run state.
    logic [CW-1:0]      r_item_cnt;
    logic [CW-1:0]      r_len [NUM_LISTS];
    logic signed [31:0] r_min [NUM_LISTS];
    logic signed [31:0] r_max [NUM_LISTS];
    logic               r_drop;
    logic [CW-1:0]      r_ucnt;

    // Unique-id table.
    logic [63:0] r_mem_uid [ITEM_CAPACITY];
    logic [31:0] r_mem_usc [ITEM_CAPACITY];
    logic [63:0] r_u_id;
    logic [31:0] r_u_sc;

    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_scan;
    logic [CW-1:0]     r_sel;
    logic [TERM_W-1:0] r_term;

    logic [63:0]     r_best_id [TOP_K_MAX];
    logic [31:0]     r_best_sc [TOP_K_MAX];
    logic [LIMW-1:0] r_n;
    logic [LIMW-1:0] r_emit;

    logic        r_o_valid;
    logic [63:0] r_o_id;
    logic [31:0] r_o_sc;
    logic        r_o_ovf;
    logic        r_o_last;

    // Load path.
    logic          ld_list_ok;
    logic [LW-1:0] ld_li;
    logic          ld_full;
    logic          ld_take;
    logic          ld_drop;

    assign ld_list_ok = {30'b0, i_list_index} < 32'(NUM_LISTS);
    assign ld_li      = LW'(i_list_index);
    assign ld_full    = r_item_cnt == CW'(ITEM_CAPACITY);
    assign ld_take    = i_cmd.load && i_entry_valid && ld_list_ok && !ld_full;
    assign ld_drop    = i_cmd.load && i_entry_valid && ld_list_ok && ld_full;

    // Divider operands for the item just read.
    logic [LW-1:0]      op_li;
    logic signed [31:0] op_min;
    logic signed [31:0] op_max;
    logic [15:0]        op_w;
    logic [15:0]        k_eff;
    logic [DVS_W-1:0]   rank_d;
    logic               flat;
    logic [32:0]        range_v;
    logic [32:0]        num_v;
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic [DVD_W-1:0]   div_q;
    logic               div_done;
    logic [32:0]        prod;

    assign op_li   = LW'(r_rd_list);
    assign op_min  = r_min[op_li];
    assign op_max  = r_max[op_li];
    assign op_w    = r_weight[r_rd_list];
    assign k_eff   = (r_k == 16'd0) ? rfk_pkg::K_DEFAULT : r_k;
    assign rank_d  = DVS_W'(k_eff) + ((DVS_W'(r_rd_rank) + DVS_W'(1)) << 4);
    assign flat    = op_max <= op_min;
    assign range_v = {op_max[31], op_max} - {op_min[31], op_min};
    assign num_v   = r_dist[r_rd_list] ? ({op_max[31], op_max} - {r_rd_score[31], r_rd_score})
                                       : ({r_rd_score[31], r_rd_score} - {op_min[31], op_min});

    always_comb begin
        if (!r_mode) begin
            dvd = DVD_W'({op_w, 8'b0});
            dvs = rank_d;
        end else if (flat) begin
            dvd = DVD_W'(65536);
            dvs = DVS_W'(1);
        end else begin
            dvd = {num_v[31:0], 16'b0};
            dvs = range_v;
        end
    end

    rfk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    assign prod = 33'(op_w) * 33'(div_q[16:0]);

    // Saturating accumulation into an existing unique entry.
    logic [32:0] sum_v;
    logic [31:0] sum_sat;

    assign sum_v   = {1'b0, r_u_sc} + 33'(r_term);
    assign sum_sat = sum_v[32] ? 32'hFFFF_FFFF : sum_v[31:0];

    // Top-k insertion position.
    logic [LIMW-1:0] lim;
    logic [LIMW-1:0] pos;
    logic            ins_ok;

    always_comb begin
        lim = ({27'b0, r_top_k} > 32'(TOP_K_MAX)) ? LIMW'(TOP_K_MAX) : LIMW'(r_top_k);
        pos = '0;
        for (int i = 0; i < TOP_K_MAX; i++) begin
            if ((LIMW'(i) < r_n) && (r_best_sc[i] >= r_u_sc)) begin
                pos = pos + LIMW'(1);
            end
        end
        ins_ok = pos < lim;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_k      <= rfk_pkg::K_DEFAULT;
            r_top_k  <= rfk_pkg::TOP_K_RESET;
            r_dist   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_weight[i] <= rfk_pkg::WEIGHT_RESET;
            end
        end else if (i_cfg_we) begin
            case (rfk_pkg::t_reg_idx'(i_cfg_index))
                rfk_pkg::REG_FUSION_MODE: r_mode      <= i_cfg_data[0];
                rfk_pkg::REG_RANK_K:      r_k         <= i_cfg_data;
                rfk_pkg::REG_TOP_K:       r_top_k     <= i_cfg_data[4:0];
                rfk_pkg::REG_WEIGHT0:     r_weight[0] <= i_cfg_data;
                rfk_pkg::REG_WEIGHT1:     r_weight[1] <= i_cfg_data;
                rfk_pkg::REG_WEIGHT2:     r_weight[2] <= i_cfg_data;
                rfk_pkg::REG_WEIGHT3:     r_weight[3] <= i_cfg_data;
                rfk_pkg::REG_DIST_MASK:   r_dist      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Item store: written while loading, read back one entry at a time.
    always_ff @(posedge i_clk) begin
        if (ld_take) begin
            r_mem_id[r_item_cnt[AW-1:0]]    <= i_in_chunk_id;
            r_mem_score[r_item_cnt[AW-1:0]] <= i_raw_score;
            r_mem_list[r_item_cnt[AW-1:0]]  <= i_list_index;
            r_mem_rank[r_item_cnt[AW-1:0]]  <= r_len[ld_li][AW-1:0];
        end
        if (i_cmd.item_rd) begin
            r_rd_id    <= r_mem_id[r_idx[AW-1:0]];
            r_rd_score <= r_mem_score[r_idx[AW-1:0]];
            r_rd_list  <= r_mem_list[r_idx[AW-1:0]];
            r_rd_rank  <= r_mem_rank[r_idx[AW-1:0]];
        end
    end

    // Run state, cleared at reset and after each set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_run) begin
            r_item_cnt <= '0;
            r_ucnt     <= '0;
            r_drop     <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_len[i] <= '0;
                r_min[i] <= 32'sh7FFF_FFFF;
                r_max[i] <= 32'sh8000_0000;
            end
        end else begin
            if (ld_take) begin
                r_item_cnt   <= r_item_cnt + CW'(1);
                r_len[ld_li] <= r_len[ld_li] + CW'(1);
                if (i_raw_score < r_min[ld_li]) begin
                    r_min[ld_li] <= i_raw_score;
                end
                if (i_raw_score > r_max[ld_li]) begin
                    r_max[ld_li] <= i_raw_score;
                end
            end
            if (ld_drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.uniq_append && (r_ucnt != CW'(ITEM_CAPACITY))) begin
                r_ucnt <= r_ucnt + CW'(1);
            end
        end
    end

    // Unique-id table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_u_id <= r_mem_uid[r_scan[AW-1:0]];
            r_u_sc <= r_mem_usc[r_scan[AW-1:0]];
        end else if (i_cmd.sel_rd) begin
            r_u_id <= r_mem_uid[r_sel[AW-1:0]];
            r_u_sc <= r_mem_usc[r_sel[AW-1:0]];
        end
        if (i_cmd.uniq_update) begin
            r_mem_usc[r_scan[AW-1:0]] <= sum_sat;
        end else if (i_cmd.uniq_append && (r_ucnt != CW'(ITEM_CAPACITY))) begin
            r_mem_uid[r_ucnt[AW-1:0]] <= r_rd_id;
            r_mem_usc[r_ucnt[AW-1:0]] <= 32'(r_term);
        end
    end

    // Sequencing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_scan <= '0;
            r_sel  <= '0;
            r_n    <= '0;
            r_emit <= '0;
        end else begin
            if (i_cmd.fuse_init) begin
                r_idx <= '0;
            end else if (i_cmd.item_next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.mul_capture) begin
                r_scan <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + CW'(1);
            end
            if (i_cmd.sel_init) begin
                r_sel  <= '0;
                r_n    <= '0;
                r_emit <= '0;
            end else begin
                if (i_cmd.sel_insert) begin
                    r_sel <= r_sel + CW'(1);
                    if (ins_ok && (r_n < lim)) begin
                        r_n <= r_n + LIMW'(1);
                    end
                end
                if (i_cmd.emit) begin
                    r_emit <= r_emit + LIMW'(1);
                end
            end
        end
    end

    // Fused term of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_capture) begin
            r_term <= r_mode ? TERM_W'(prod >> 12) : div_q[TERM_W-1:0];
        end
    end

    // Sorted top-k list; entries below the insertion point move down one place.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_insert && ins_ok) begin
            if (pos == '0) begin
                r_best_id[0] <= r_u_id;
                r_best_sc[0] <= r_u_sc;
            end
            for (int j = 1; j < TOP_K_MAX; j++) begin
                if (LIMW'(j) == pos) begin
                    r_best_id[j] <= r_u_id;
                    r_best_sc[j] <= r_u_sc;
                end else if ((LIMW'(j) > pos) && (LIMW'(j) < lim)) begin
                    r_best_id[j] <= r_best_id[j-1];
                    r_best_sc[j] <= r_best_sc[j-1];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_o_id   <= r_best_id[r_emit[KW-1:0]];
            r_o_sc   <= r_best_sc[r_emit[KW-1:0]];
            r_o_ovf  <= r_drop;
            r_o_last <= (r_emit + LIMW'(1)) == r_n;
        end
    end

    assign o_stat.items_done = r_idx == r_item_cnt;
    assign o_stat.div_done   = div_done;
    assign o_stat.scan_end   = r_scan == r_ucnt;
    assign o_stat.id_match   = r_u_id == r_rd_id;
    assign o_stat.sel_done   = r_sel == r_ucnt;
    assign o_stat.emit_done  = r_emit == r_n;

    assign o_valid        = r_o_valid;
    assign o_out_chunk_id = r_o_id;
    assign o_fused_score  = r_o_sc;
    assign o_overflow     = r_o_ovf;
    assign o_out_last     = r_o_last;

endmodule

// ----- hw/rtl/rfk_ctrl.sv -----
// Sequencer that steps the datapath through load, fusion, selection and output.
module rfk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_in_last,
    input  rfk_pkg::t_stat i_stat,
    output rfk_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITEM_RD,
        ST_ITEM_WAIT,
        ST_DIV_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SEL_RD,
        ST_SEL_INS,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.fuse_init = 1'b1;
                        n_state         = ST_ITEM_RD;
                    end
                end
            end
            ST_ITEM_RD: begin
                if (i_stat.items_done) begin
                    o_cmd.sel_init = 1'b1;
                    n_state        = ST_SEL_RD;
                end else begin
                    o_cmd.item_rd = 1'b1;
                    n_state       = ST_ITEM_WAIT;
                end
            end
            ST_ITEM_WAIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.mul_capture = 1'b1;
                    n_state           = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.uniq_append = 1'b1;
                    o_cmd.item_next   = 1'b1;
                    n_state           = ST_ITEM_RD;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_stat.id_match) begin
                    o_cmd.uniq_update = 1'b1;
                    o_cmd.item_next   = 1'b1;
                    n_state           = ST_ITEM_RD;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = ST_SCAN_RD;
                end
            end
            ST_SEL_RD: begin
                if (i_stat.sel_done) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.sel_rd = 1'b1;
                    n_state      = ST_SEL_INS;
                end
            end
            ST_SEL_INS: begin
                o_cmd.sel_insert = 1'b1;
                n_state          = ST_SEL_RD;
            end
            ST_EMIT: begin
                if (i_stat.emit_done) begin
                    o_cmd.clr_run = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != ST_IDLE;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/rank_fusion_top_k_top.sv -----
// Top level of the rank fusion top-k block: sequencer plus datapath.
//
// Usage: entries of up to four ranked lists are presented on the input ports and
// taken as a beat at each clock edge where start is high and busy is low. While
// loading, busy stays low, so one entry is taken per cycle. The beat with
// i_in_last high closes the set (it may also carry an entry) and raises busy.
// The block then walks its item store. Each stored entry goes through the
// one-bit-per-cycle 48-step divider and a linear search of the unique-id table
// for its id; an id that turns out to be new is appended. Selection then reads
// each unique id and inserts it into the top-k list. Up to top_k results follow,
// one per cycle, each shown for exactly one cycle with o_valid high; o_out_last
// marks the final one. An empty set or top_k of zero gives no results. Busy
// drops once the last result has been presented, and the run state is then
// clear for the next set. The receiver cannot stall: every result beat is taken
// as it appears. Configuration is written through i_cfg_valid / o_cfg_ready
// (always ready) with a register index and 16-bit data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Synchronous active-low reset restores register defaults and empties the run.
module rank_fusion_top_k_top #(
    parameter int unsigned NUM_LISTS     = 4,
    parameter int unsigned ITEM_CAPACITY = 256,
    parameter int unsigned TOP_K_MAX     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_list_index,
    input  logic [63:0]                      i_in_chunk_id,
    input  logic signed [31:0]               i_raw_score,
    input  logic                             i_entry_valid,
    input  logic                             i_in_last,
    output logic                             o_valid,
    output logic [63:0]                      o_out_chunk_id,
    output logic [31:0]                      o_fused_score,
    output logic                             o_overflow,
    output logic                             o_out_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    rfk_pkg::t_cmd  cmd;
    rfk_pkg::t_stat stat;
    logic           ctrl_busy;

    // Register writes never conflict with the datapath, so the port is always ready.
    assign o_cfg_ready = 1'b1;
    assign busy        = ctrl_busy;

    rfk_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start && !ctrl_busy),
        .i_in_last (i_in_last),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (ctrl_busy)
    );

    rfk_datapath #(
        .NUM_LISTS     (NUM_LISTS),
        .ITEM_CAPACITY (ITEM_CAPACITY),
        .TOP_K_MAX     (TOP_K_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_list_index   (i_list_index),
        .i_in_chunk_id  (i_in_chunk_id),
        .i_raw_score    (i_raw_score),
        .i_entry_valid  (i_entry_valid),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_out_chunk_id (o_out_chunk_id),
        .o_fused_score  (o_fused_score),
        .o_overflow     (o_overflow),
        .o_out_last     (o_out_last)
    );

endmodule

// ----- verif/rank_fusion_top_k_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the rank fusion top-k block with its own fusion predictor.
module rank_fusion_top_k_top_tb;

    localparam int LISTS    = 4;
    localparam int CAPACITY = 256;
    localparam int KMAX     = 16;
    // Cycles without any beat before the run is declared hung; ample even for a full
    // item store of all distinct ids.
    localparam int STALL_LIMIT = 400000;

    // One input beat of the block.
    typedef struct {
        logic [1:0]         lst;
        logic [63:0]        id;
        logic signed [31:0] score;
        logic               ent;
        logic               last;
    } entry_t;

    // One result beat of the block.
    typedef struct {
        logic [63:0] id;
        logic [31:0] score;
        logic        ovf;
        logic        last;
    } ranked_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_list_index = '0;
    logic [63:0] i_in_chunk_id = '0;
    logic signed [31:0] i_raw_score = '0;
    logic i_entry_valid = 1'b0;
    logic i_in_last = 1'b0;
    logic o_valid;
    logic [63:0] o_out_chunk_id;
    logic [31:0] o_fused_score;
    logic o_overflow;
    logic o_out_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rfk_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rfk_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    rank_fusion_top_k_top DUT (.*);

    // The clock has a period of 2 ns.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Beats waiting to be sent, and the ranked results that the block still owes.
    entry_t  pending_entries[$];
    ranked_t owed_results[$];
    int      idle_pct = 25;
    int      error_count = 0;
    int      quiet_cycles = 0;

    // Predictor copy of the configuration registers.
    logic        mode_score;
    logic [15:0] k_offset;
    logic [4:0]  top_limit;
    logic [15:0] list_weight[LISTS];
    logic [3:0]  dist_lists;

    // Predictor copy of the run state.
    logic [63:0] stored_id[CAPACITY];
    longint      stored_score[CAPACITY];
    logic [1:0]  stored_list[CAPACITY];
    int          stored_rank[CAPACITY];
    int          stored_count;
    int          list_len[LISTS];
    longint      list_lo[LISTS];
    longint      list_hi[LISTS];
    logic        lost_entries;

    task automatic clear_run_state();
        stored_count = 0;
        lost_entries = 1'b0;
        for (int l = 0; l < LISTS; l++) begin
            list_len[l] = 0;
            list_lo[l]  = 64'sd2147483647;
            list_hi[l]  = -64'sd2147483648;
        end
    endtask

    // Contribution of one stored entry to its id's fused score.
    function automatic longint unsigned entry_term(int i);
        longint unsigned w, d, norm, num, span;
        int l;
        l = stored_list[i];
        w = list_weight[l];
        if (!mode_score) begin
            d = ((k_offset != 0) ? k_offset : rfk_pkg::K_DEFAULT) + (stored_rank[i] + 1) * 16;
            return (w * 256) / d;
        end
        if (list_hi[l] <= list_lo[l]) begin
            norm = 65536;
        end else begin
            span = list_hi[l] - list_lo[l];
            num  = dist_lists[l] ? list_hi[l] - stored_score[i] : stored_score[i] - list_lo[l];
            norm = (num << 16) / span;
        end
        return (w * norm) >> 12;
    endfunction

    // Fuses the stored entries per unique id and queues the best ones, best first.
    task automatic fuse_and_rank();
        logic [63:0]     uniq_id[CAPACITY];
        longint unsigned uniq_sum[CAPACITY];
        logic [63:0]     best_id[KMAX];
        longint unsigned best_sum[KMAX];
        longint unsigned t;
        int uniq_n, n, lim, pos, j;
        ranked_t r;
        uniq_n = 0;
        n = 0;
        lim = (top_limit > KMAX) ? KMAX : top_limit;
        for (int i = 0; i < stored_count; i++) begin
            t = entry_term(i);
            for (j = 0; j < uniq_n; j++)
                if (uniq_id[j] == stored_id[i]) break;
            if (j < uniq_n) begin
                uniq_sum[j] = uniq_sum[j] + t;
                if (uniq_sum[j] > 64'hFFFF_FFFF) uniq_sum[j] = 64'hFFFF_FFFF;
            end else begin
                uniq_id[uniq_n]  = stored_id[i];
                uniq_sum[uniq_n] = (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
                uniq_n++;
            end
        end
        // Insertion keeps earlier ids ahead of later ones with an equal score.
        for (int i = 0; i < uniq_n; i++) begin
            pos = n;
            while (pos > 0 && best_sum[pos-1] < uniq_sum[i]) pos--;
            if (pos < lim) begin
                for (j = (n < lim) ? n : lim - 1; j > pos; j--) begin
                    best_id[j]  = best_id[j-1];
                    best_sum[j] = best_sum[j-1];
                end
                best_id[pos]  = uniq_id[i];
                best_sum[pos] = uniq_sum[i];
                if (n < lim) n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.id    = best_id[i];
            r.score = best_sum[i][31:0];
            r.ovf   = lost_entries;
            r.last  = (i == n - 1);
            owed_results.insert(owed_results.size(), r);
        end
        clear_run_state();
    endtask

    // Applies one accepted beat to the predictor.
    task automatic absorb_entry(entry_t e);
        if (e.ent) begin
            if (stored_count < CAPACITY) begin
                stored_id[stored_count]    = e.id;
                stored_score[stored_count] = e.score;
                stored_list[stored_count]  = e.lst;
                stored_rank[stored_count]  = list_len[e.lst];
                stored_count++;
                list_len[e.lst]++;
                if (e.score < list_lo[e.lst]) list_lo[e.lst] = e.score;
                if (e.score > list_hi[e.lst]) list_hi[e.lst] = e.score;
            end else begin
                lost_entries = 1'b1;
            end
        end
        if (e.last) fuse_and_rank();
    endtask

    // Driver: an item beat is taken when start is high and busy is low. Every
    // signal gets a single assignment per edge, so a held start is never toggled.
    always @(posedge i_clk) begin
        entry_t e;
        logic accepted, send;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) absorb_entry(pending_entries.pop_front());
            if (start && !accepted) begin
                send = 1'b1;
            end else begin
                send = (pending_entries.size() != 0) && ($urandom_range(99) >= idle_pct);
                if (send) begin
                    e = pending_entries[0];
                    i_list_index  <= e.lst;
                    i_in_chunk_id <= e.id;
                    i_raw_score   <= e.score;
                    i_entry_valid <= e.ent;
                    i_in_last     <= e.last;
                end
            end
            start <= send;
        end
    end

    // Monitor: each result beat is checked against the oldest owed result.
    always @(posedge i_clk) begin
        ranked_t want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
            if (o_valid) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result beat: out_chunk_id %h", o_out_chunk_id);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_out_chunk_id !== want.id) begin
                        $error("out_chunk_id: expected %h, got %h", want.id, o_out_chunk_id);
                        error_count++;
                    end
                    if (o_fused_score !== want.score) begin
                        $error("fused_score: expected %h, got %h", want.score, o_fused_score);
                        error_count++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %b, got %b", want.ovf, o_overflow);
                        error_count++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, o_out_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Writes one register through the configuration channel and updates the predictor.
    task automatic write_register(rfk_pkg::t_reg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rfk_pkg::REG_FUSION_MODE: mode_score = data[0];
            rfk_pkg::REG_RANK_K:      k_offset = data;
            rfk_pkg::REG_TOP_K:       top_limit = data[4:0];
            rfk_pkg::REG_WEIGHT0:     list_weight[0] = data;
            rfk_pkg::REG_WEIGHT1:     list_weight[1] = data;
            rfk_pkg::REG_WEIGHT2:     list_weight[2] = data;
            rfk_pkg::REG_WEIGHT3:     list_weight[3] = data;
            rfk_pkg::REG_DIST_MASK:   dist_lists = data[3:0];
            default: ;
        endcase
    endtask

    // Waits until every beat is sent, every result has arrived and the block is
    // idle. A set that closes empty gives no result, so busy is watched as well.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_entries.size() != 0 || start || owed_results.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic randomize_config();
        write_register(rfk_pkg::REG_FUSION_MODE, 16'($urandom_range(1)));
        write_register(rfk_pkg::REG_RANK_K, pick16(16'd1, 16'hFFFF));
        write_register(rfk_pkg::REG_TOP_K,
                       ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(16, 1)));
        write_register(rfk_pkg::REG_WEIGHT0, pick16(16'd0, 16'hFFFF));
        write_register(rfk_pkg::REG_WEIGHT1, pick16(16'd0, 16'hFFFF));
        write_register(rfk_pkg::REG_WEIGHT2, pick16(16'd0, 16'hFFFF));
        write_register(rfk_pkg::REG_WEIGHT3, pick16(16'd0, 16'hFFFF));
        write_register(rfk_pkg::REG_DIST_MASK, 16'($urandom_range(15)));
    endtask

    function automatic entry_t make_entry(logic [1:0] lst, logic [63:0] id,
                                          logic signed [31:0] score, logic ent, logic last);
        entry_t e;
        e.lst = lst;
        e.id = id;
        e.score = score;
        e.ent = ent;
        e.last = last;
        return e;
    endfunction

    function automatic logic signed [31:0] random_score();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(3) - 1;
            2: return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(200000)) - 32'sd100000;
        endcase
    endfunction

    // Queues one well-formed set: random lists and scores over a small id pool so
    // that ids repeat across lists. A few beats carry no entry.
    task automatic queue_random_set(int len, int pool_size);
        logic [63:0] pool[8];
        logic [63:0] id;
        for (int i = 0; i < pool_size; i++) pool[i] = {$urandom, $urandom};
        for (int i = 0; i < len; i++) begin
            id = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                          : pool[$urandom_range(pool_size - 1)];
            pending_entries.insert(pending_entries.size(),
                                   make_entry(2'($urandom_range(3)), id, random_score(),
                                              $urandom_range(9) != 0, i == len - 1));
        end
    endtask

    // Main sequence: reset, a directed part, then three random phases.
    initial begin
        int sent;
        mode_score = 1'b0;
        k_offset = rfk_pkg::K_DEFAULT;
        top_limit = rfk_pkg::TOP_K_RESET;
        for (int l = 0; l < LISTS; l++) list_weight[l] = rfk_pkg::WEIGHT_RESET;
        dist_lists = 4'd0;
        clear_run_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration, rank fusion: extreme ids and scores, repeated ids.
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd0, 64'd0, 32'sh8000_0000, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd1, '1, 32'sh7FFF_FFFF, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd0, '1, 32'sd0, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd2, 64'd0, 32'sd5, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd3, 64'h5555_AAAA_5555_AAAA, -32'sd1, 1'b1, 1'b1));
        // An empty set, then a set closed by a beat that carries no entry.
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd3, '1, 32'sd0, 1'b0, 1'b1));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd1, 64'd7, 32'sd9, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd2, 64'd7, 32'sd9, 1'b0, 1'b1));
        drain();

        // Score fusion with distance lists, extreme weights, a list whose scores
        // are all equal and ids that tie on their fused score.
        write_register(rfk_pkg::REG_FUSION_MODE, 16'd1);
        write_register(rfk_pkg::REG_DIST_MASK, 16'hA);
        write_register(rfk_pkg::REG_WEIGHT0, 16'd0);
        write_register(rfk_pkg::REG_WEIGHT1, 16'hFFFF);
        write_register(rfk_pkg::REG_WEIGHT2, 16'd4096);
        write_register(rfk_pkg::REG_WEIGHT3, 16'hFFFF);
        write_register(rfk_pkg::REG_TOP_K, 16'd16);
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd1, 64'd1, 32'sd100, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd1, 64'd2, 32'sd100, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd2, 64'd3, 32'sh8000_0000, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd2, 64'd4, 32'sh7FFF_FFFF, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd3, 64'd3, -32'sd50, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd3, 64'd4, 32'sd50, 1'b1, 1'b0));
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd0, 64'd5, 32'sd1, 1'b1, 1'b1));
        drain();

        // A top_k of zero gives nothing; a top_k above the maximum is clipped;
        // a k of zero falls back to its default.
        write_register(rfk_pkg::REG_TOP_K, 16'd0);
        pending_entries.insert(pending_entries.size(),
                               make_entry(2'd0, 64'd9, 32'sd1, 1'b1, 1'b1));
        drain();
        write_register(rfk_pkg::REG_FUSION_MODE, 16'd0);
        write_register(rfk_pkg::REG_TOP_K, 16'd31);
        write_register(rfk_pkg::REG_RANK_K, 16'd0);
        for (int i = 0; i < 20; i++)
            pending_entries.insert(pending_entries.size(),
                                   make_entry(i[1:0], 64'd100 + i, 32'sd0, 1'b1, i == 19));
        drain();

        // Random phases: the sender idles now and then, then often, then never. Each
        // phase runs two configurations, and the first also fills the item store
        // past its capacity once.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 25 : (phase == 1) ? 76 : 0;
            for (int half = 0; half < 2; half++) begin
                randomize_config();
                if (phase == 0 && half == 0) begin
                    write_register(rfk_pkg::REG_TOP_K, 16'd16);
                    queue_random_set(CAPACITY + 6, 8);
                    drain();
                end
                sent = 0;
                while (sent < 30) begin
                    // Mostly short sets, now and then a longer one.
                    automatic int len = ($urandom_range(7) == 0) ? $urandom_range(40, 13)
                                                                 : $urandom_range(12, 1);
                    queue_random_set(len, $urandom_range(8, 1));
                    sent += len;
                end
                drain();
            end
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
